/* rtl/sync_header_xor_frame_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_XOR_FRAME_PARSER_ASSERT_SVH
`define SYNC_HEADER_XOR_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication
`define SHXFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");

// Next-cycle implication
`define SHXFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`endif

/* rtl/shxfp_pkg.sv */
// ----------------------------------------------------------------------------
// shxfp_pkg
// Constants and types used by the frame parser.
// ----------------------------------------------------------------------------
package shxfp_pkg;

    // Payload bytes carried in each frame
    localparam int PAYLOAD_BYTES = 5;
    // Payload fields on the result channel
    localparam int OUT_PAYLOAD   = 5;
    // Payload fields actually filled from the store
    localparam int OUT_COPY      = (PAYLOAD_BYTES < OUT_PAYLOAD) ? PAYLOAD_BYTES : OUT_PAYLOAD;
    // Payload counter / store index width
    localparam int CNT_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hBB;

    typedef enum logic [2:0] {
        PH_HEAD1 = 3'd0,
        PH_HEAD2 = 3'd1,
        PH_INDEX = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]                  dest_index;
        logic [7:0]                  msg_type;
        logic [OUT_PAYLOAD-1:0][7:0] payload;
    } result_t;

endpackage

/* rtl/shxfp_if.sv */
// ----------------------------------------------------------------------------
// shxfp channel interfaces
// Valid/ready channels for received bytes and for decoded frames.
// ----------------------------------------------------------------------------

// Received byte stream
interface shxfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded frame results
interface shxfp_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] dest_index;
    logic [7:0] msg_type;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;

    modport source (output valid, output dest_index, output msg_type,
                    output payload_0, output payload_1, output payload_2,
                    output payload_3, output payload_4, input ready);
    modport sink   (input valid, input dest_index, input msg_type,
                    input payload_0, input payload_1, input payload_2,
                    input payload_3, input payload_4, output ready);
endinterface

/* rtl/sync_header_xor_frame_parser.sv */
// ----------------------------------------------------------------------------
// sync_header_xor_frame_parser
// Hunts for AA BB index type payload[5] check frames in a byte stream and
// emits index, type and payload of every frame whose XOR check passes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transaction
//  --------+-----+------------------------------------------+------------------
//  rx      | in  | rx_byte                                  | one received byte
//  frame   | out | dest_index, msg_type, payload_0..4       | one good frame
//
//  One byte is decided per cycle while rx.ready is high; the parse state
//  updates on the same edge the byte is taken, and a good frame lands in
//  the result register then; frame.valid follows in the next cycle.
//  rx.ready drops only while a result sits in the result register and
//  frame.ready is low; a result is taken and a new byte accepted together.
//  Reset (rst_n low, asynchronous) returns the parser to header hunting.
// ----------------------------------------------------------------------------
`include "sync_header_xor_frame_parser_assert.svh"

module sync_header_xor_frame_parser
(
    input  logic          clk,
    input  logic          rst_n,
    shxfp_byte_if.sink    rx,
    shxfp_frame_if.source frame
);

    shxfp_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                    xor_reg, xor_next;
    logic [7:0]                    index_reg, index_next;
    logic [7:0]                    type_reg, type_next;
    logic [shxfp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]                    store_reg [shxfp_pkg::PAYLOAD_BYTES];
    logic                          store_we;
    logic                          hit;
    logic                          rx_acc;
    logic                          out_valid_reg;
    shxfp_pkg::result_t            res_reg, res_next;

    // Byte accepted whenever the result register is free or being drained
    assign rx.ready = !out_valid_reg || frame.ready;
    assign rx_acc   = rx.valid && rx.ready;

    // Next parse state for the byte on the input
    always_comb
    begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        index_next = index_reg;
        type_next  = type_reg;
        cnt_next   = cnt_reg;
        store_we   = 1'b0;
        hit        = 1'b0;
        case (phase_reg)
            shxfp_pkg::PH_HEAD2:
            begin
                if (rx.rx_byte == shxfp_pkg::HDR_SECOND)
                begin
                    xor_next   = xor_reg ^ rx.rx_byte;
                    phase_next = shxfp_pkg::PH_INDEX;
                end
                else if (rx.rx_byte == shxfp_pkg::HDR_FIRST)
                begin
                    xor_next   = shxfp_pkg::HDR_FIRST;
                    phase_next = shxfp_pkg::PH_HEAD2;
                end
                else
                begin
                    phase_next = shxfp_pkg::PH_HEAD1;
                end
            end
            shxfp_pkg::PH_INDEX:
            begin
                xor_next   = xor_reg ^ rx.rx_byte;
                index_next = rx.rx_byte;
                cnt_next   = '0;
                phase_next = shxfp_pkg::PH_TYPE;
            end
            shxfp_pkg::PH_TYPE:
            begin
                xor_next   = xor_reg ^ rx.rx_byte;
                type_next  = rx.rx_byte;
                phase_next = shxfp_pkg::PH_DATA;
            end
            shxfp_pkg::PH_DATA:
            begin
                xor_next = xor_reg ^ rx.rx_byte;
                store_we = 1'b1;
                if (cnt_reg == shxfp_pkg::CNT_W'(shxfp_pkg::PAYLOAD_BYTES - 1))
                begin
                    cnt_next   = '0;
                    phase_next = shxfp_pkg::PH_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            shxfp_pkg::PH_CHECK:
            begin
                if (rx.rx_byte == xor_reg)
                begin
                    hit        = 1'b1;
                    phase_next = shxfp_pkg::PH_HEAD1;
                end
                else if (rx.rx_byte == shxfp_pkg::HDR_FIRST)
                begin
                    xor_next   = shxfp_pkg::HDR_FIRST;
                    phase_next = shxfp_pkg::PH_HEAD2;
                end
                else
                begin
                    phase_next = shxfp_pkg::PH_HEAD1;
                end
            end
            default:
            begin
                // Hunting for the first header byte
                if (rx.rx_byte == shxfp_pkg::HDR_FIRST)
                begin
                    xor_next   = shxfp_pkg::HDR_FIRST;
                    phase_next = shxfp_pkg::PH_HEAD2;
                end
                else
                begin
                    phase_next = shxfp_pkg::PH_HEAD1;
                end
            end
        endcase
    end

    // Result word from the held header fields and the payload store
    always_comb
    begin
        res_next            = '0;
        res_next.dest_index = index_reg;
        res_next.msg_type   = type_reg;
        for (int i = 0; i < shxfp_pkg::OUT_COPY; i++)
        begin
            res_next.payload[i] = store_reg[i];
        end
    end

    // Parse control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= shxfp_pkg::PH_HEAD1;
            xor_reg   <= '0;
            index_reg <= '0;
            type_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (rx_acc)
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            index_reg <= index_next;
            type_reg  <= type_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload store, no reset: every entry is written before a check passes
    always_ff @(posedge clk)
    begin
        if (rx_acc && store_we)
        begin
            store_reg[cnt_reg] <= rx.rx_byte;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rx_acc && hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (rx_acc && hit)
        begin
            res_reg <= res_next;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.dest_index = res_reg.dest_index;
    assign frame.msg_type   = res_reg.msg_type;
    assign frame.payload_0  = res_reg.payload[0];
    assign frame.payload_1  = res_reg.payload[1];
    assign frame.payload_2  = res_reg.payload[2];
    assign frame.payload_3  = res_reg.payload[3];
    assign frame.payload_4  = res_reg.payload[4];

    // A passing check byte always yields a result next cycle
    `SHXFP_ASSERT_NEXT(a_check_hit_emits, rx_acc && phase_reg == shxfp_pkg::PH_CHECK && rx.rx_byte == xor_reg, out_valid_reg)

    // No result appears from any byte outside the check phase
    `SHXFP_ASSERT_NEXT(a_result_only_from_check, rx_acc && !out_valid_reg && phase_reg != shxfp_pkg::PH_CHECK, !out_valid_reg)

    // Payload counter stays inside the store while collecting data
    `SHXFP_ASSERT_NOW(a_count_in_range, phase_reg == shxfp_pkg::PH_DATA, cnt_reg <= shxfp_pkg::CNT_W'(shxfp_pkg::PAYLOAD_BYTES - 1))

    // Leaving the data phase always resets the counter for the next frame
    `SHXFP_ASSERT_NEXT(a_count_cleared_at_check, rx_acc && phase_reg == shxfp_pkg::PH_DATA && phase_next == shxfp_pkg::PH_CHECK, cnt_reg == '0)

endmodule
